// ----- hdl/scm_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// scm_pkg
// Shared widths, fixed-point constants and polynomial coefficients for the
// minimax sine/cosine pipeline.
// ---------------------------------------------------------------------------
package scm_pkg;

    // Default output fraction bits (Q1.F result format)
    localparam int OUT_FRAC_BITS_DEF = 16;

    // Datapath widths
    localparam int ANGLE_W = 32;  // Q8.24 angle
    localparam int P_W     = 63;  // angle times 1/(2*pi), Q.56 quotient
    localparam int Q_W     = 7;   // signed turn count
    localparam int QM_W    = 6;   // turn count magnitude
    localparam int Y_W     = 36;  // reduced angle, Q.32
    localparam int Y30_W   = 32;  // folded angle, Q.30
    localparam int Y2_W    = 32;  // squared angle, Q.30, never negative
    localparam int ACC_W   = 34;  // Horner accumulator, Q.32
    localparam int V_W     = 35;  // final sine/cosine before rounding, Q.32
    localparam int Q_SHIFT = 30;  // product scaling in Q.30 multiplies
    localparam int Q_POS   = 56;  // binary point of the quotient product
    localparam int N_COEF  = 6;   // coefficients per polynomial

    typedef logic signed [ACC_W-1:0] coef_t;

    // Fixed-point constants
    localparam logic signed [30:0]      INV2PI_Q32 = 31'sd683565276;
    localparam logic signed [Y_W-1:0]   TWOPI_Q32  = 36'sd26986075409;
    localparam logic signed [Y_W-1:0]   PI_Q32     = 36'sd13493037705;
    localparam logic signed [Y_W-1:0]   HALFPI_Q32 = 36'sd6746518852;
    localparam logic [P_W-1:0]          Q_RND      = P_W'(1) << (Q_POS - 1);

    // Odd sine polynomial, highest order first, Q.32
    localparam coef_t SIN_COEF [0:N_COEF-1] = '{
        -34'sd103, 34'sd11822, -34'sd852159, 34'sd35791384,
        -34'sd715827897, 34'sd4294967296
    };

    // Even cosine polynomial, highest order first, Q.32
    localparam coef_t COS_COEF [0:N_COEF-1] = '{
        -34'sd1119, 34'sd106346, -34'sd5965013, 34'sd178956848,
        -34'sd2147483648, 34'sd4294967296
    };

endpackage
`default_nettype wire

// ----- hdl/sine_cosine_minimax.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sine_cosine_minimax
// Sine and cosine of a Q8.24 radian angle by minimax polynomials, Q1.F out.
// ---------------------------------------------------------------------------
//  Channel   Ports                          Word contents
//  input     s_valid s_ready s_angle        angle, signed Q8.24 radians
//  result    m_valid m_ready m_sine m_cosine sin/cos, signed Q1.F, clamped
//
//  Twelve register stages; one word enters per cycle unless the output word
//  is held on m_ready. The depth is set by the five chained Horner
//  multiplies plus reduction, fold, square, sine scaling and rounding.
//  aresetn clears only the valid bits. A stall on m_ready freezes every
//  stage together, and s_ready drops only while the output word is held.
// ---------------------------------------------------------------------------
module sine_cosine_minimax #(
    parameter int OUT_FRAC_BITS = scm_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [scm_pkg::ANGLE_W-1:0]  s_angle,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed      [OUT_FRAC_BITS+1:0]     m_sine,
    output logic signed      [OUT_FRAC_BITS+1:0]     m_cosine
);

    localparam int OUT_W  = OUT_FRAC_BITS + 2;
    localparam int NSTG   = 12;
    localparam int NSTEP  = scm_pkg::N_COEF - 1;
    localparam int ACC_W  = scm_pkg::ACC_W;
    localparam int V_W    = scm_pkg::V_W;
    localparam logic signed [V_W:0] RND     = (V_W+1)'(1) << (31 - OUT_FRAC_BITS);
    localparam logic signed [V_W:0] LIM_POS = (V_W+1)'(1) << OUT_FRAC_BITS;
    localparam logic signed [V_W:0] LIM_NEG = -LIM_POS;

    logic                               en;
    logic [NSTG-1:0]                    vld_reg;

    logic signed [scm_pkg::P_W-1:0]     p_next, p_reg;
    logic signed [scm_pkg::ANGLE_W-1:0] a1_reg, a2_reg;
    logic [scm_pkg::P_W-1:0]            mag, rsum;
    logic [scm_pkg::QM_W-1:0]           qm;
    logic signed [scm_pkg::Q_W-1:0]     q_next, q2_reg;
    logic signed [42:0]                 qt, y_full;
    logic signed [scm_pkg::Y_W-1:0]     y3_reg, yf;
    logic                               flip_next;
    logic signed [scm_pkg::Y30_W-1:0]   y30_next, y30_reg4;
    logic                               flip_reg4;
    logic signed [2*scm_pkg::Y30_W-1:0] sq;
    logic [scm_pkg::Y2_W-1:0]           y2_next;

    logic [scm_pkg::Y2_W-1:0]           y2_pipe_reg   [0:NSTEP-1];
    logic signed [scm_pkg::Y30_W-1:0]   y30_pipe_reg  [0:NSTEP];
    logic                               flip_pipe_reg [0:NSTEP];
    logic signed [ACC_W-1:0]            sin_acc [0:NSTEP-1];
    logic signed [ACC_W-1:0]            cos_acc [0:NSTEP-1];

    logic signed [ACC_W+scm_pkg::Y30_W-1:0] prod_s;
    logic signed [V_W-1:0]              s_next, c_next, cext, s11_reg, c11_reg;
    logic [OUT_W-1:0]                   sine_next, cosine_next;
    logic [OUT_W-1:0]                   sine_reg, cosine_reg;

    // Round half up to Q1.F and clamp to plus or minus one
    function automatic logic [OUT_W-1:0] rnd_sat(input logic signed [V_W-1:0] v);
        logic signed [V_W:0] sum;
        logic signed [V_W:0] r;
        sum = $signed({v[V_W-1], v}) + RND;
        r   = sum >>> (32 - OUT_FRAC_BITS);
        if (r > LIM_POS) begin
            r = LIM_POS;
        end else if (r < LIM_NEG) begin
            r = LIM_NEG;
        end
        return r[OUT_W-1:0];
    endfunction

    // Advance the whole pipeline unless the output word is held
    assign en      = !vld_reg[NSTG-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_valid};
        end
    end

    // Stage 1: scale angle by 1/(2*pi)
    assign p_next = s_angle * scm_pkg::INV2PI_Q32;

    // Stage 2: round turn count half away from zero
    always_comb begin
        mag    = p_reg[scm_pkg::P_W-1] ? scm_pkg::P_W'(-p_reg) : scm_pkg::P_W'(p_reg);
        rsum   = mag + scm_pkg::Q_RND;
        qm     = rsum[scm_pkg::Q_POS +: scm_pkg::QM_W];
        q_next = p_reg[scm_pkg::P_W-1] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    end

    // Stage 3: subtract whole turns
    always_comb begin
        qt     = q2_reg * scm_pkg::TWOPI_Q32;
        y_full = $signed({a2_reg, 8'b0}) - qt;
    end

    // Stage 4: fold into [-pi/2, pi/2], flag cosine sign flip
    always_comb begin
        yf        = y3_reg;
        flip_next = 1'b0;
        if (y3_reg > scm_pkg::HALFPI_Q32) begin
            yf        = scm_pkg::PI_Q32 - y3_reg;
            flip_next = 1'b1;
        end else if (y3_reg < -scm_pkg::HALFPI_Q32) begin
            yf        = -scm_pkg::PI_Q32 - y3_reg;
            flip_next = 1'b1;
        end
        y30_next = yf[scm_pkg::Y30_W+1:2];
    end

    // Stage 5: square the folded angle
    always_comb begin
        sq      = y30_reg4 * y30_reg4;
        y2_next = sq[scm_pkg::Q_SHIFT +: scm_pkg::Y2_W];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg            <= p_next;
            a1_reg           <= s_angle;
            q2_reg           <= q_next;
            a2_reg           <= a1_reg;
            y3_reg           <= y_full[scm_pkg::Y_W-1:0];
            y30_reg4         <= y30_next;
            flip_reg4        <= flip_next;
            y2_pipe_reg[0]   <= y2_next;
            y30_pipe_reg[0]  <= y30_reg4;
            flip_pipe_reg[0] <= flip_reg4;
        end
    end

    // Stages 6 to 10: Horner steps for both polynomials in lockstep
    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        if (k == 0) begin : g_first
            scm_horner_step u_sin (
                .aclk    (aclk),
                .en      (en),
                .acc_in  (scm_pkg::SIN_COEF[0]),
                .y2_in   (y2_pipe_reg[0]),
                .coef    (scm_pkg::SIN_COEF[1]),
                .acc_out (sin_acc[0])
            );
            scm_horner_step u_cos (
                .aclk    (aclk),
                .en      (en),
                .acc_in  (scm_pkg::COS_COEF[0]),
                .y2_in   (y2_pipe_reg[0]),
                .coef    (scm_pkg::COS_COEF[1]),
                .acc_out (cos_acc[0])
            );
        end else begin : g_rest
            scm_horner_step u_sin (
                .aclk    (aclk),
                .en      (en),
                .acc_in  (sin_acc[k-1]),
                .y2_in   (y2_pipe_reg[k]),
                .coef    (scm_pkg::SIN_COEF[k+1]),
                .acc_out (sin_acc[k])
            );
            scm_horner_step u_cos (
                .aclk    (aclk),
                .en      (en),
                .acc_in  (cos_acc[k-1]),
                .y2_in   (y2_pipe_reg[k]),
                .coef    (scm_pkg::COS_COEF[k+1]),
                .acc_out (cos_acc[k])
            );
        end

        // Carry angle terms and flip flag beside the accumulators
        always_ff @(posedge aclk) begin
            if (en) begin
                y30_pipe_reg[k+1]  <= y30_pipe_reg[k];
                flip_pipe_reg[k+1] <= flip_pipe_reg[k];
            end
        end

        if (k < NSTEP - 1) begin : g_y2
            always_ff @(posedge aclk) begin
                if (en) begin
                    y2_pipe_reg[k+1] <= y2_pipe_reg[k];
                end
            end
        end
    end

    // Stage 11: scale sine polynomial by the angle, apply cosine sign
    always_comb begin
        prod_s = sin_acc[NSTEP-1] * y30_pipe_reg[NSTEP];
        s_next = prod_s[scm_pkg::Q_SHIFT +: V_W];
        cext   = $signed({cos_acc[NSTEP-1][ACC_W-1], cos_acc[NSTEP-1]});
        c_next = flip_pipe_reg[NSTEP] ? -cext : cext;
    end

    // Stage 12: round and saturate to the output format
    always_comb begin
        sine_next   = rnd_sat(s11_reg);
        cosine_next = rnd_sat(c11_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s11_reg    <= s_next;
            c11_reg    <= c_next;
            sine_reg   <= sine_next;
            cosine_reg <= cosine_next;
        end
    end

    assign m_sine   = $signed(sine_reg);
    assign m_cosine = $signed(cosine_reg);

endmodule
`default_nettype wire

// ----- hdl/scm_horner_step.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// scm_horner_step
// One registered Horner step: acc_out = asr(acc_in * y2, 30) + coef.
// ---------------------------------------------------------------------------
module scm_horner_step (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire logic signed [scm_pkg::ACC_W-1:0]  acc_in,
    input  wire logic        [scm_pkg::Y2_W-1:0]   y2_in,
    input  wire logic signed [scm_pkg::ACC_W-1:0]  coef,
    output logic signed      [scm_pkg::ACC_W-1:0]  acc_out
);

    localparam int PROD_W = scm_pkg::ACC_W + scm_pkg::Y2_W + 1;

    logic signed [PROD_W-1:0]          prod;
    logic signed [scm_pkg::ACC_W-1:0]  acc_next;
    logic signed [scm_pkg::ACC_W-1:0]  acc_reg;

    // Multiply by the squared angle, rescale to Q.32, add the next term
    always_comb begin
        prod     = acc_in * $signed({1'b0, y2_in});
        acc_next = $signed(prod[scm_pkg::Q_SHIFT +: scm_pkg::ACC_W]) + coef;
    end

    // Hold while the pipeline is stalled
    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg <= acc_next;
        end
    end

    assign acc_out = acc_reg;

endmodule
`default_nettype wire
